// ===== hw/rtl/assert_macros.svh =====
// assert_macros.svh: assertion helpers for the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent implication check under synchronous reset.
`define CHK_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication check.
`define CHK_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hw/rtl/lpfm_pkg.sv =====
// ----------------------------------------------------------------------------
// lpfm_pkg
// Types, codes and constants shared by the page frame manager.
// ----------------------------------------------------------------------------
package lpfm_pkg;

   localparam int unsigned POOL_FRAMES_DEF = 16;
   localparam int unsigned MAX_PAGES_DEF   = 4096;
   localparam int unsigned PAGE_W          = 12;
   localparam int unsigned FRAME_W         = 4;
   localparam int unsigned COUNT_W         = 13;
   localparam int unsigned REQ_PAGE_W      = 16;
   localparam int unsigned MAX_RESULTS     = 16;

   typedef enum logic [1:0] {
      REQ_ACCESS    = 2'd0,
      REQ_MARK      = 2'd1,
      REQ_FLUSH     = 2'd2,
      REQ_FLUSH_ALL = 2'd3
   } req_code_type;

   typedef enum logic [2:0] {
      ST_DONE     = 3'd0,
      ST_LOAD     = 3'd1,
      ST_ZERO     = 3'd2,
      ST_RANGE    = 3'd3,
      ST_NOT_RES  = 3'd4
   } status_code_type;

   typedef struct packed {
      logic [1:0]            req_type;
      logic [REQ_PAGE_W-1:0] page_number;
   } req_type;

   typedef struct packed {
      logic [2:0]         status;
      logic [FRAME_W-1:0] frame_index;
      logic               evict_valid;
      logic [PAGE_W-1:0]  evict_page;
      logic               writeback_valid;
      logic [PAGE_W-1:0]  writeback_page;
      logic [COUNT_W-1:0] next_free_page;
      logic               last;
   } rsp_type;

   // Classified command handed from front to back.
   typedef struct packed {
      logic [1:0]            code;
      logic                  out_of_range;
      logic [REQ_PAGE_W-1:0] page;
   } cmd_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_LOOKUP,
      BK_VICTIM,
      BK_COMMIT,
      BK_SCAN,
      BK_EMIT
   } bk_state_type;

endpackage

// ===== hw/rtl/lpfm_front.sv =====
// ----------------------------------------------------------------------------
// lpfm_front
// Accepts request beats, classifies them, and queues commands for the back.
// ----------------------------------------------------------------------------
module lpfm_front #(
   parameter int unsigned MAX_PAGES = lpfm_pkg::MAX_PAGES_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  lpfm_pkg::req_type req_data,
   output logic              cmd_valid,
   input  logic              cmd_ready,
   output lpfm_pkg::cmd_type cmd_data
);
   import lpfm_pkg::*;

   cmd_type q_ff [2];
   cmd_type q_in;
   logic    wr_ptr_ff, rd_ptr_ff;
   logic [1:0] cnt_ff;
   logic    push, pop;

   assign req_ready = (cnt_ff != 2'd2);
   assign push      = req_valid && req_ready;
   assign cmd_valid = (cnt_ff != 2'd0);
   assign pop       = cmd_valid && cmd_ready;
   assign cmd_data  = q_ff[rd_ptr_ff];

   always_comb begin
      q_in.code = req_data.req_type;
      q_in.page = req_data.page_number;
      q_in.out_of_range = ({16'd0, req_data.page_number} >= 32'(MAX_PAGES));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         if (push) wr_ptr_ff <= ~wr_ptr_ff;
         if (pop)  rd_ptr_ff <= ~rd_ptr_ff;
         cnt_ff <= cnt_ff + {1'b0, push} - {1'b0, pop};
      end
   end

   always_ff @(posedge clock) begin
      if (push) q_ff[wr_ptr_ff] <= q_in;
   end

   `include "assert_macros.svh"
   `CHK_IMPL(a_no_overflow, clock, reset, cnt_ff == 2'd2, !push, "queue overflow")
   `CHK_IMPL(a_no_underflow, clock, reset, cnt_ff == 2'd0, !pop, "queue underflow")
endmodule

// ===== hw/rtl/lpfm_back.sv =====
// ----------------------------------------------------------------------------
// lpfm_back
// Executes commands against the frame table and produces result beats.
// ----------------------------------------------------------------------------
module lpfm_back #(
   parameter int unsigned POOL_FRAMES = lpfm_pkg::POOL_FRAMES_DEF,
   localparam int unsigned FI_W = (POOL_FRAMES > 1) ? $clog2(POOL_FRAMES) : 1
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          cmd_valid,
   output logic                          cmd_ready,
   input  lpfm_pkg::cmd_type             cmd_data,
   input  logic [lpfm_pkg::COUNT_W-1:0]  init_count,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output lpfm_pkg::rsp_type             rsp_data
);
   import lpfm_pkg::*;

   logic [POOL_FRAMES-1:0] valid_ff, dirty_ff;
   logic [PAGE_W-1:0]      page_ff [POOL_FRAMES];
   logic [FI_W-1:0]        rank_ff [POOL_FRAMES];
   logic [COUNT_W-1:0]     touched_ff;

   bk_state_type state_ff, state_in;
   cmd_type      cmd_ff;
   logic         hit_ff;
   logic [FI_W-1:0] hit_idx_ff, vic_ff;
   logic         have_free_ff;
   logic [FI_W-1:0] free_idx_ff;
   logic [FI_W:0]   scan_ff;
   logic [4:0]      nout_ff;
   logic            out_full_ff;
   rsp_type         out_ff;

   logic [COUNT_W-1:0] count_cur;
   assign count_cur = (touched_ff > init_count) ? touched_ff : init_count;

   // Combinational match and free search over the pool (independent elements).
   logic [POOL_FRAMES-1:0] match_vec;
   logic [FI_W-1:0]        match_idx, free_idx, vic_idx;
   logic                   match_any, free_any;
   always_comb begin
      match_idx = '0;
      match_any = 1'b0;
      free_idx  = '0;
      free_any  = 1'b0;
      for (int i = POOL_FRAMES - 1; i >= 0; i--) begin
         match_vec[i] = valid_ff[i] && (cmd_ff.page[PAGE_W-1:0] == page_ff[i]) &&
                        (cmd_ff.page[REQ_PAGE_W-1:PAGE_W] == '0);
         if (match_vec[i]) begin
            match_idx = FI_W'(i);
            match_any = 1'b1;
         end
         if (!valid_ff[i]) begin
            free_idx = FI_W'(i);
            free_any = 1'b1;
         end
      end
   end

   // Victim: full pool, unique ranks, so the oldest has rank POOL_FRAMES-1.
   always_comb begin
      vic_idx = '0;
      for (int i = POOL_FRAMES - 1; i >= 0; i--) begin
         if (rank_ff[i] == FI_W'(POOL_FRAMES - 1)) vic_idx = FI_W'(i);
      end
   end

   logic out_free;
   assign out_free  = !out_full_ff || rsp_ready;
   assign rsp_valid = out_full_ff;
   assign rsp_data  = out_ff;
   assign cmd_ready = (state_ff == BK_IDLE);

   logic [FI_W-1:0] scan_idx;
   assign scan_idx = scan_ff[FI_W-1:0];

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BK_IDLE:   if (cmd_valid) state_in = BK_LOOKUP;
         BK_LOOKUP: begin
            if (cmd_ff.code == REQ_FLUSH_ALL) state_in = BK_SCAN;
            else if (cmd_ff.code == REQ_ACCESS && !cmd_ff.out_of_range && !match_any)
               state_in = BK_VICTIM;
            else state_in = BK_EMIT;
         end
         BK_VICTIM: state_in = BK_COMMIT;
         BK_COMMIT: if (out_free) state_in = BK_IDLE;
         BK_EMIT:   if (out_free) state_in = BK_IDLE;
         BK_SCAN: begin
            if (out_free && scan_ff == (FI_W+1)'(POOL_FRAMES)) state_in = BK_IDLE;
         end
         default:   state_in = BK_IDLE;
      endcase
   end

   // Frame written by a miss and the frame made most recent.
   logic [FI_W-1:0] fill_idx;
   assign fill_idx = have_free_ff ? free_idx_ff : vic_ff;

   always_ff @(posedge clock) begin
      rsp_type beat_nx;
      logic    full_nx;
      logic    more;
      if (reset) begin
         state_ff    <= BK_IDLE;
         valid_ff    <= '0;
         dirty_ff    <= '0;
         touched_ff  <= '0;
         out_full_ff <= 1'b0;
      end else begin
         // Hold the output beat unless a new one is built below.
         beat_nx = out_ff;
         full_nx = out_full_ff && !rsp_ready;
         more    = 1'b0;
         state_ff <= state_in;
         unique case (state_ff)
            BK_IDLE: begin
               if (cmd_valid) cmd_ff <= cmd_data;
               scan_ff <= '0;
               nout_ff <= '0;
            end
            BK_LOOKUP: begin
               hit_ff       <= match_any;
               hit_idx_ff   <= match_idx;
               have_free_ff <= free_any;
               free_idx_ff  <= free_idx;
               vic_ff       <= vic_idx;
            end
            BK_VICTIM: ;
            BK_EMIT: begin
               if (out_free) begin
                  full_nx = 1'b1;
                  beat_nx = '0;
                  beat_nx.last = 1'b1;
                  beat_nx.next_free_page = count_cur;
                  if (cmd_ff.code == REQ_ACCESS) begin
                     if (cmd_ff.out_of_range) beat_nx.status = ST_RANGE;
                     else begin
                        beat_nx.frame_index = 4'(hit_idx_ff);
                        for (int i = 0; i < POOL_FRAMES; i++)
                           if (valid_ff[i] && i != int'(hit_idx_ff) &&
                               rank_ff[i] < rank_ff[hit_idx_ff])
                              rank_ff[i] <= rank_ff[i] + 1'b1;
                        rank_ff[hit_idx_ff] <= '0;
                     end
                  end else if (!hit_ff) beat_nx.status = ST_NOT_RES;
                  else begin
                     beat_nx.frame_index = 4'(hit_idx_ff);
                     if (cmd_ff.code == REQ_MARK) dirty_ff[hit_idx_ff] <= 1'b1;
                     else begin
                        dirty_ff[hit_idx_ff]   <= 1'b0;
                        beat_nx.writeback_valid = 1'b1;
                        beat_nx.writeback_page  = page_ff[hit_idx_ff];
                     end
                  end
               end
            end
            BK_COMMIT: begin
               if (out_free) begin
                  full_nx = 1'b1;
                  beat_nx = '0;
                  beat_nx.last = 1'b1;
                  beat_nx.frame_index = 4'(fill_idx);
                  beat_nx.status = ({3'd0, cmd_ff.page} < {6'd0, count_cur}) ?
                                   ST_LOAD : ST_ZERO;
                  if ({3'd0, cmd_ff.page} >= {6'd0, touched_ff}) begin
                     touched_ff <= cmd_ff.page[COUNT_W-1:0] + 1'b1;
                     beat_nx.next_free_page = (cmd_ff.page[COUNT_W-1:0] + 1'b1 > init_count)
                        ? cmd_ff.page[COUNT_W-1:0] + 1'b1 : init_count;
                  end else beat_nx.next_free_page = count_cur;
                  if (!have_free_ff) begin
                     beat_nx.evict_valid = 1'b1;
                     beat_nx.evict_page  = page_ff[vic_ff];
                     if (dirty_ff[vic_ff]) begin
                        beat_nx.writeback_valid = 1'b1;
                        beat_nx.writeback_page  = page_ff[vic_ff];
                     end
                  end
                  for (int i = 0; i < POOL_FRAMES; i++)
                     if (valid_ff[i] && i != int'(fill_idx) &&
                         (!valid_ff[fill_idx] || rank_ff[i] < rank_ff[fill_idx]))
                        rank_ff[i] <= rank_ff[i] + 1'b1;
                  rank_ff[fill_idx]  <= '0;
                  valid_ff[fill_idx] <= 1'b1;
                  dirty_ff[fill_idx] <= 1'b0;
                  page_ff[fill_idx]  <= cmd_ff.page[PAGE_W-1:0];
               end
            end
            BK_SCAN: begin
               if (out_free) begin
                  if (scan_ff == (FI_W+1)'(POOL_FRAMES)) begin
                     // Drop a terminator only when nothing was emitted.
                     if (nout_ff == '0) begin
                        full_nx = 1'b1;
                        beat_nx = '0;
                        beat_nx.last = 1'b1;
                        beat_nx.next_free_page = count_cur;
                     end
                  end else begin
                     scan_ff <= scan_ff + 1'b1;
                     if (valid_ff[scan_idx] && dirty_ff[scan_idx] &&
                         nout_ff < 5'(MAX_RESULTS)) begin
                        for (int j = 0; j < POOL_FRAMES; j++)
                           if (j > int'(scan_idx) && valid_ff[j] && dirty_ff[j]) more = 1'b1;
                        dirty_ff[scan_idx] <= 1'b0;
                        nout_ff <= nout_ff + 1'b1;
                        full_nx = 1'b1;
                        beat_nx = '0;
                        beat_nx.frame_index     = 4'(scan_idx);
                        beat_nx.writeback_valid = 1'b1;
                        beat_nx.writeback_page  = page_ff[scan_idx];
                        beat_nx.next_free_page  = count_cur;
                        beat_nx.last = !more || (nout_ff == 5'(MAX_RESULTS - 1));
                     end
                  end
               end
            end
            default: ;
         endcase
         out_ff      <= beat_nx;
         out_full_ff <= full_nx;
      end
   end

   `include "assert_macros.svh"
   `CHK_IMPL(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, out_free == 1'b0,
             "output overwrite")
   `CHK_NEXT(a_lookup_follows, clock, reset, state_ff == BK_IDLE && cmd_valid,
             state_ff == BK_LOOKUP, "lookup skipped")
   `CHK_IMPL(a_idle_ready, clock, reset, state_ff != BK_IDLE, !cmd_ready,
             "took command while busy")
endmodule

// ===== hw/rtl/lru_page_frame_manager.sv =====
// ----------------------------------------------------------------------------
// lru_page_frame_manager
// LRU page frame manager with dirty tracking and write-back requests.
// ----------------------------------------------------------------------------
//  channel | direction | beat
//  req     | in        | req_type, page_number
//  rsp     | out       | status ... last, one or more beats per request
//  csr     | in        | initial_page_count
//
// An access runs LOOKUP and EMIT on a hit or error, LOOKUP, VICTIM and COMMIT
// on a miss; flush-all scans one frame per cycle while the output is free.
// Reset empties the pool and the touched page count, clears the register.
// A two-entry command queue lets requests land while the back end waits
// on rsp_ready; a full output register holds the back end.
module lru_page_frame_manager #(
   parameter int unsigned POOL_FRAMES = lpfm_pkg::POOL_FRAMES_DEF,
   parameter int unsigned MAX_PAGES   = lpfm_pkg::MAX_PAGES_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  lpfm_pkg::req_type            req_data,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output lpfm_pkg::rsp_type            rsp_data,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [lpfm_pkg::COUNT_W-1:0] csr_data
);
   import lpfm_pkg::*;

   logic [COUNT_W-1:0] init_count_ff;
   logic    cmd_valid, cmd_ready;
   cmd_type cmd_data;

   // Always take register writes.
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) init_count_ff <= '0;
      else if (csr_valid) init_count_ff <= csr_data;
   end

   lpfm_front #(.MAX_PAGES(MAX_PAGES)) u_front (
      .clock, .reset, .req_valid, .req_ready, .req_data,
      .cmd_valid, .cmd_ready, .cmd_data
   );

   lpfm_back #(.POOL_FRAMES(POOL_FRAMES)) u_back (
      .clock, .reset, .cmd_valid, .cmd_ready, .cmd_data,
      .init_count(init_count_ff), .rsp_valid, .rsp_ready, .rsp_data
   );
endmodule
